// ===== design/b64d_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// b64d_pkg
// Types, constants and the character map shared by the base64 stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

	// Character codes used by the sextet map.
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CH_DIGIT_0 = 8'h30;
	localparam logic [7:0] CH_DIGIT_9 = 8'h39;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_PAD     = 8'h3D;

	// Sextet offsets of the character classes.
	localparam logic [5:0] SX_LOWER_BASE = 6'd26;
	localparam logic [5:0] SX_DIGIT_BASE = 6'd52;
	localparam logic [5:0] SX_PLUS       = 6'd62;
	localparam logic [5:0] SX_SLASH      = 6'd63;
	localparam logic [5:0] SX_PAD        = 6'd0;

	// Result queue geometry.
	localparam int RQ_DEPTH = 8;
	localparam int RQ_AW    = 3;
	localparam int RQ_LW    = 4;
	localparam int MAX_RES  = 3;

	typedef struct packed {
		logic [7:0] in_char;
		logic       end_of_text;
	} b64d_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       error;
		logic       last_of_run;
	} b64d_out_t;

	// Results written into the queue in one cycle.
	typedef struct packed {
		logic [1:0]      cnt;
		b64d_out_t [2:0] ent;
	} b64d_push_t;

	typedef struct packed {
		logic       valid;
		logic [5:0] sextet;
	} b64d_map_t;

	function automatic b64d_map_t map_sextet(input logic [7:0] c);
		b64d_map_t r;
		r.valid  = 1'b1;
		r.sextet = SX_PAD;
		if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
			r.sextet = 6'(c - CH_UPPER_A);
		end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
			r.sextet = 6'(c - CH_LOWER_A) + SX_LOWER_BASE;
		end else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
			r.sextet = 6'(c - CH_DIGIT_0) + SX_DIGIT_BASE;
		end else if (c == CH_PLUS) begin
			r.sextet = SX_PLUS;
		end else if (c == CH_SLASH) begin
			r.sextet = SX_SLASH;
		end else if (c == CH_PAD) begin
			r.sextet = SX_PAD;
		end else begin
			r.valid = 1'b0;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== design/b64d_resq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// b64d_resq
// Result queue: takes up to three results per cycle, hands out one per cycle while out_stall is low.
// ----------------------------------------------------------------------------
module b64d_resq
	import b64d_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire b64d_push_t       push,
	output logic [RQ_LW-1:0]      level,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output b64d_out_t             out_data
);

	b64d_out_t             mem_q [RQ_DEPTH];
	logic [RQ_AW-1:0]      wr_ptr_q;
	logic [RQ_AW-1:0]      rd_ptr_q;
	logic [RQ_LW-1:0]      level_q;
	logic                  pop;

	assign level     = level_q;
	assign out_valid = (level_q != '0);
	assign out_data  = mem_q[rd_ptr_q];
	assign pop       = out_valid && !out_stall;

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RES; i++) begin
			if (2'(i) < push.cnt) begin
				mem_q[wr_ptr_q + RQ_AW'(i)] <= push.ent[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + RQ_AW'(push.cnt);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + RQ_AW'(1);
			end
			level_q <= level_q + RQ_LW'(push.cnt) - RQ_LW'(pop);
		end
	end

endmodule
`default_nettype wire

// ===== design/base64_stream_decoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Streaming base64 decoder: one text character in, up to three bytes out.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_stall/in_data carries one character and an end of
// text flag per transaction. Output channel out_valid/out_stall/out_data
// carries one decoded byte or one error result per transaction; last_of_run
// marks the final result caused by one character. The cfg_valid/cfg_ready
// channel writes the output byte limit per text and is always ready.
// An accepted character lands in the input register and is decoded from there
// into an eight-entry result queue, so its first result passes the input
// register and the queue before it is offered. One character is taken every
// cycle as long as the queue has room for three more results; the output
// drains one result per cycle while out_stall is low, so a full group of four
// characters (three bytes) never limits the input rate. When the receiver
// stalls, the queue fills and in_stall rises once a character waits in the
// input register and fewer than three entries are free.
// Reset empties the queue and the input register, clears the decoder state and
// sets the limit to 65535. End of text clears the decoder state but keeps the
// limit.
// ----------------------------------------------------------------------------
module base64_stream_decoder
	import b64d_pkg::*;
#(
	parameter int COUNT_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire b64d_in_t    in_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output b64d_out_t        out_data,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data
);

	localparam int CMPW = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 2;

	// Input register.
	logic                  valid_s1;
	logic [7:0]            char_s1;
	logic                  eot_s1;

	// Decoder state.
	logic [15:0]           out_limit_q;
	logic [5:0]            sextet_q [3];
	logic [1:0]            pos_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic                  halted_q;

	logic [RQ_LW-1:0]      level;
	logic                  room;
	logic                  advance;
	logic                  in_accept;
	b64d_map_t             map;
	logic [2:0]            reached;
	logic [2:0]            emit;
	logic [1:0]            n_bytes;
	logic                  active;
	logic [7:0]            dec_byte [3];
	b64d_push_t            push;
	logic                  group_done;

	assign cfg_ready = 1'b1;
	assign room      = (level <= RQ_LW'(RQ_DEPTH - MAX_RES));
	assign in_stall  = valid_s1 && !room;
	assign in_accept = in_valid && !in_stall;
	assign advance   = valid_s1 && room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			char_s1 <= in_data.in_char;
			eot_s1  <= in_data.end_of_text;
		end
	end

	// Limit checks for the current count and the next two bytes of a group.
	always_comb begin
		logic [CMPW-1:0] cnt_x;
		logic [CMPW-1:0] lim_x;
		logic [CMPW-1:0] max_x;
		cnt_x = CMPW'(cnt_q);
		lim_x = CMPW'(out_limit_q);
		max_x = CMPW'({COUNT_BITS{1'b1}});
		for (int i = 0; i < MAX_RES; i++) begin
			reached[i] = ((cnt_x + CMPW'(i)) >= lim_x) || ((cnt_x + CMPW'(i)) >= max_x);
		end
	end

	assign map     = map_sextet(char_s1);
	assign active  = !halted_q && !reached[0];
	assign emit[0] = !reached[0];
	assign emit[1] = emit[0] && !reached[1];
	assign emit[2] = emit[1] && !reached[2];
	assign n_bytes = 2'(emit[0]) + 2'(emit[1]) + 2'(emit[2]);

	assign dec_byte[0] = {sextet_q[0], sextet_q[1][5:4]};
	assign dec_byte[1] = {sextet_q[1][3:0], sextet_q[2][5:2]};
	assign dec_byte[2] = {sextet_q[2][1:0], map.sextet};

	assign group_done = advance && active && map.valid && (pos_q == 2'd3);

	always_comb begin
		push.cnt = 2'd0;
		for (int i = 0; i < MAX_RES; i++) begin
			push.ent[i].out_byte    = dec_byte[i];
			push.ent[i].error       = 1'b0;
			push.ent[i].last_of_run = 1'b0;
		end
		push.ent[0].last_of_run = emit[0] && !emit[1];
		push.ent[1].last_of_run = emit[1] && !emit[2];
		push.ent[2].last_of_run = emit[2];
		if (advance && active) begin
			if (!map.valid) begin
				push.cnt                = 2'd1;
				push.ent[0].out_byte    = 8'd0;
				push.ent[0].error       = 1'b1;
				push.ent[0].last_of_run = 1'b1;
			end else if (pos_q == 2'd3) begin
				push.cnt = n_bytes;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_limit_q <= 16'hFFFF;
		end else if (cfg_valid && cfg_ready) begin
			out_limit_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sextet_q[0] <= '0;
			sextet_q[1] <= '0;
			sextet_q[2] <= '0;
			pos_q       <= '0;
			cnt_q       <= '0;
			halted_q    <= 1'b0;
		end else if (advance) begin
			if (eot_s1) begin
				sextet_q[0] <= '0;
				sextet_q[1] <= '0;
				sextet_q[2] <= '0;
				pos_q       <= '0;
				cnt_q       <= '0;
				halted_q    <= 1'b0;
			end else if (active) begin
				if (!map.valid) begin
					halted_q <= 1'b1;
				end else if (pos_q == 2'd3) begin
					sextet_q[0] <= '0;
					sextet_q[1] <= '0;
					sextet_q[2] <= '0;
					pos_q       <= '0;
					cnt_q       <= cnt_q + COUNT_BITS'(n_bytes);
				end else begin
					sextet_q[pos_q] <= map.sextet;
					pos_q           <= pos_q + 2'd1;
				end
			end
		end
	end

	b64d_resq u_resq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.level     (level),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

`ifndef SYNTH
	// The queue must never be asked to hold more than it has.
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level <= RQ_LW'(RQ_DEPTH))
		else $error("result queue level exceeds its depth");

	// An error result whose character carries no end of text leaves the decoder halted.
	a_error_halts: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && push.cnt != 2'd0 && push.ent[0].error && !eot_s1) |=> halted_q)
		else $error("decoder not halted after an error result");

	// Within a text the byte count never moves backward.
	a_count_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !eot_s1) |=> (cnt_q >= $past(cnt_q)))
		else $error("byte count decreased within a text");

	// A completed group always returns to the first position.
	a_group_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		group_done |=> (pos_q == 2'd0))
		else $error("group position not cleared after a full group");
`endif

endmodule
`default_nettype wire
